// ----- hw/rtl/sbif_pkg.sv -----
// Package for the servo bus instruction framer.
// Holds the operation codes, instruction bytes and framing constants.
// No dependencies.
`default_nettype none

package sbif_pkg;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_REG_WRITE = 3'd2,
    OP_ACTION    = 3'd3,
    OP_RESET     = 3'd4
  } sbif_op_e;

  // Instruction bytes on the wire
  localparam logic [7:0] INS_READ      = 8'h02;
  localparam logic [7:0] INS_WRITE     = 8'h03;
  localparam logic [7:0] INS_REG_WRITE = 8'h04;
  localparam logic [7:0] INS_ACTION    = 8'h05;
  localparam logic [7:0] INS_RESET     = 8'h06;

  // Framing
  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] BCAST_ID   = 8'hFE;
  localparam logic [7:0] LEN_SHORT  = 8'h02;  // action, factory reset
  localparam logic [7:0] LEN_READ   = 8'h04;
  localparam logic [7:0] LEN_WR_BASE = 8'h03; // plus data byte count

  // Fixed bytes of every packet ahead of the data: header x2, id, length,
  // instruction, address.
  localparam int unsigned FIXED_BYTES = 6;

  // The running sum also takes in both FF header bytes (FF+FF = FE mod 256),
  // so it starts at 02 to cancel them.
  localparam logic [7:0] SUM_SEED = 8'h02;

endpackage

`default_nettype wire

// ----- hw/rtl/sbif_req_if.sv -----
// Request channel of the servo bus instruction framer.
// Carries valid, ready and the request fields. No dependencies.
`default_nettype none

interface sbif_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] servo_id;
  logic [7:0] reg_address;
  logic [7:0] byte_count;
  logic [7:0] data_lo;
  logic [7:0] data_hi;

  modport source (
    output valid, opcode, servo_id, reg_address, byte_count, data_lo, data_hi,
    input  ready
  );

  modport sink (
    input  valid, opcode, servo_id, reg_address, byte_count, data_lo, data_hi,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/sbif_tx_if.sv -----
// Byte channel of the servo bus instruction framer.
// Carries valid, ready, the packet byte and the end marker. No dependencies.
`default_nettype none

interface sbif_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (
    output valid, tx_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, tx_byte, last_byte,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/sbif_serializer.sv -----
// Byte shift register, running checksum and output register of the framer.
// Depends on sbif_pkg and sbif_tx_if.
`default_nettype none

module sbif_serializer
  import sbif_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned CNT_W = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic [7:0]       pkt_i [DEPTH],
  input  wire logic [CNT_W-1:0] len_i,
  output logic                  busy_o,
  sbif_tx_if.source             tx_o
);

  logic [7:0]       sh_q [DEPTH];
  logic [7:0]       sh_d [DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ck_q, ck_d;
  logic [7:0]       sum_q, sum_d;
  logic             vld_q, vld_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             advance;

  assign busy_o    = (cnt_q != '0) || ck_q;
  // output register is free or being taken this cycle
  assign advance   = !vld_q || tx_o.ready;

  assign tx_o.valid     = vld_q;
  assign tx_o.tx_byte   = byte_q;
  assign tx_o.last_byte = last_q;

  // Next byte: shift one out of the register, then the checksum
  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    ck_d   = ck_q;
    sum_d  = sum_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    if (load_i) begin
      sh_d  = pkt_i;
      cnt_d = len_i;
      ck_d  = 1'b1;
      sum_d = SUM_SEED;
      // previous end marker may leave on this same edge
      if (tx_o.ready) begin
        vld_d = 1'b0;
      end
    end else if (advance) begin
      if (cnt_q != '0) begin
        byte_d = sh_q[0];
        last_d = 1'b0;
        vld_d  = 1'b1;
        sum_d  = sum_q + sh_q[0];
        cnt_d  = cnt_q - CNT_W'(1);
        for (int i = 0; i < int'(DEPTH) - 1; i++) begin
          sh_d[i] = sh_q[i+1];
        end
        sh_d[DEPTH-1] = '0;
      end else if (ck_q) begin
        byte_d = ~sum_q;  // FF minus sum
        last_d = 1'b1;
        vld_d  = 1'b1;
        ck_d   = 1'b0;
      end else begin
        vld_d  = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ck_q  <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ck_q  <= ck_d;
      vld_q <= vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    sum_q  <= sum_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  // A new packet is loaded only once the previous one is fully shifted out
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !busy_o)
    else $error("packet loaded while serializer busy");

  // A loaded packet has bytes pending on the next cycle
  a_load_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (cnt_q != '0) && ck_q)
    else $error("load did not fill serializer");

  // The end marker never waits while its own checksum is still owed
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && last_q) |-> !(ck_q && (cnt_q == '0)))
    else $error("end marker with bytes still pending");

  // A stalled byte stays in the output register
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !tx_o.ready) |=> vld_q && $stable(byte_q) && $stable(last_q))
    else $error("stalled byte dropped");

endmodule

`default_nettype wire

// ----- hw/rtl/servo_bus_instruction_framer.sv -----
// Top level of the servo bus instruction framer: builds the packet for one
// request and hands it to the serializer. Depends on sbif_pkg, sbif_req_if,
// sbif_tx_if and sbif_serializer.
//
//  channel | dir | carries                                          | accepted
//  req_i   | in  | opcode, servo_id, reg_address, byte_count, data | valid&ready
//  tx_o    | out | tx_byte, last_byte (one packet byte per beat)    | valid&ready
//
// A packet of L bytes (6 to 6+MAX_WRITE_BYTES+1) leaves at one byte per cycle
// from the byte shift register while tx_o is ready.
// req_i is ready whenever the shift register and checksum are drained; the
// last byte may still wait in the output register.
// Undefined opcodes are accepted and produce no bytes.
// Reset clears the byte count, checksum flag and output valid.
`default_nettype none

module servo_bus_instruction_framer
  import sbif_pkg::*;
#(
  parameter int unsigned MAX_WRITE_BYTES = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sbif_req_if.sink  req_i,
  sbif_tx_if.source tx_o
);

  localparam int unsigned DEPTH = FIXED_BYTES + MAX_WRITE_BYTES;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned N_W   = $clog2(MAX_WRITE_BYTES + 1);

  logic [7:0]       pkt [DEPTH];
  logic [CNT_W-1:0] len;
  logic             op_ok;
  logic             busy;
  logic             accept;
  logic [N_W-1:0]   n_wr;
  logic [7:0]       data [2];
  sbif_op_e         op;

  assign op      = sbif_op_e'(req_i.opcode);
  assign req_i.ready = !busy;
  assign accept  = req_i.valid && !busy;
  assign data[0] = req_i.data_lo;
  assign data[1] = req_i.data_hi;

  // Write data count, saturated
  assign n_wr = (req_i.byte_count > 8'(MAX_WRITE_BYTES)) ?
                N_W'(MAX_WRITE_BYTES) : req_i.byte_count[N_W-1:0];

  // Packet bytes ahead of the checksum
  always_comb begin
    for (int i = 0; i < int'(DEPTH); i++) begin
      pkt[i] = '0;
    end
    pkt[0] = HDR_BYTE;
    pkt[1] = HDR_BYTE;
    pkt[2] = req_i.servo_id;
    op_ok  = 1'b1;
    len    = CNT_W'(5);
    case (op)
      OP_READ: begin
        pkt[3] = LEN_READ;
        pkt[4] = INS_READ;
        pkt[5] = req_i.reg_address;
        pkt[6] = req_i.byte_count;
        len    = CNT_W'(7);
      end
      OP_WRITE, OP_REG_WRITE: begin
        pkt[3] = LEN_WR_BASE + 8'(n_wr);
        pkt[4] = (op == OP_REG_WRITE) ? INS_REG_WRITE : INS_WRITE;
        pkt[5] = req_i.reg_address;
        for (int i = 0; i < int'(MAX_WRITE_BYTES); i++) begin
          pkt[FIXED_BYTES+i] = data[i & 1];
        end
        len    = CNT_W'(FIXED_BYTES) + CNT_W'(n_wr);
      end
      OP_ACTION: begin
        pkt[2] = BCAST_ID;
        pkt[3] = LEN_SHORT;
        pkt[4] = INS_ACTION;
      end
      OP_RESET: begin
        pkt[3] = LEN_SHORT;
        pkt[4] = INS_RESET;
      end
      default: begin
        op_ok  = 1'b0;
      end
    endcase
  end

  sbif_serializer #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept && op_ok),
    .pkt_i  (pkt),
    .len_i  (len),
    .busy_o (busy),
    .tx_o   (tx_o)
  );

endmodule

`default_nettype wire

// ----- tb/sbif_frame_checker.sv -----
// Scoreboard for the servo bus instruction framer: watches both channels,
// predicts the packet bytes of every request and compares them in order.
// Depends on sbif_pkg, sbif_req_if and sbif_tx_if.
`timescale 1ns / 1ps

module sbif_frame_checker
  import sbif_pkg::*;
#(
  parameter int unsigned WRITE_LIMIT = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sbif_req_if       req_i,
  sbif_tx_if        tx_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } wire_byte_t;

  // Bytes still owed on the wire, oldest first
  wire_byte_t packet_bytes[$];
  int         failures = 0;

  // Frame one request and queue its bytes; undefined opcodes frame nothing
  function automatic void frame_packet(input logic [2:0] op, input logic [7:0] id,
                                       input logic [7:0] addr, input logic [7:0] cnt,
                                       input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0]  body[$];
    logic [7:0]  sum;
    int unsigned n;
    sum = 8'h00;
    case (op)
      OP_READ: body = '{id, LEN_READ, INS_READ, addr, cnt};
      OP_WRITE, OP_REG_WRITE: begin
        n = (cnt > WRITE_LIMIT) ? WRITE_LIMIT : cnt;
        body = '{id, LEN_WR_BASE + n[7:0],
                 (op == OP_REG_WRITE) ? INS_REG_WRITE : INS_WRITE, addr};
        if (n > 0) body.push_back(lo);
        if (n > 1) body.push_back(hi);
      end
      OP_ACTION: body = '{BCAST_ID, LEN_SHORT, INS_ACTION};
      OP_RESET:  body = '{id, LEN_SHORT, INS_RESET};
      default:   return;
    endcase
    packet_bytes.push_back('{HDR_BYTE, 1'b0});
    packet_bytes.push_back('{HDR_BYTE, 1'b0});
    foreach (body[i]) begin
      sum = sum + body[i];
      packet_bytes.push_back('{body[i], 1'b0});
    end
    // checksum is FF minus the byte sum, i.e. its complement
    packet_bytes.push_back('{~sum, 1'b1});
  endfunction

  // Outputs are checked before the request of the same edge is framed
  always @(posedge clk_i or negedge rst_ni) begin
    wire_byte_t want;
    if (!rst_ni) begin
      packet_bytes.delete();
    end else begin
      if (tx_i.valid && tx_i.ready) begin
        if (packet_bytes.size() == 0) begin
          $error("tx_byte: expected nothing, got %02h (last_byte %0b)",
                 tx_i.tx_byte, tx_i.last_byte);
          failures++;
        end else begin
          want = packet_bytes.pop_front();
          if (tx_i.tx_byte !== want.value) begin
            $error("tx_byte: expected %02h, got %02h", want.value, tx_i.tx_byte);
            failures++;
          end
          if (tx_i.last_byte !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, tx_i.last_byte);
            failures++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        frame_packet(req_i.opcode, req_i.servo_id, req_i.reg_address,
                     req_i.byte_count, req_i.data_lo, req_i.data_hi);
    end
    pending_o    = packet_bytes.size();
    fail_count_o = failures;
  end

endmodule

// ----- tb/tb_servo_bus_instruction_framer.sv -----
// Testbench top for the servo bus instruction framer: drives requests and
// byte-channel backpressure, gives the verdict. Depends on sbif_pkg, both
// channel interfaces, sbif_frame_checker and the framer itself.
`timescale 1ns / 1ps

module tb_servo_bus_instruction_framer;
  import sbif_pkg::*;

  localparam int unsigned WRITE_LIMIT  = 2;
  localparam int          RANDOM_ITEMS = 70;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          SETTLE       = 20;

  // Opcodes the block must accept and drop
  localparam logic [2:0] OP_UNDEF_A = 3'd5;
  localparam logic [2:0] OP_UNDEF_B = 3'd6;
  localparam logic [2:0] OP_UNDEF_C = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sbif_req_if req_bus ();
  sbif_tx_if  tx_bus ();

  int fail_count;
  int pending_bytes;

  // Shared between the request driver and the byte sink
  bit no_idle  = 1'b0;
  bit hold_off = 1'b0;

  servo_bus_instruction_framer #(
    .MAX_WRITE_BYTES(WRITE_LIMIT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .tx_o  (tx_bus)
  );

  sbif_frame_checker #(
    .WRITE_LIMIT(WRITE_LIMIT)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .tx_i        (tx_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending_bytes)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle stretch: mostly short, now and then long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_count();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a falling edge; returns at a falling edge, with the request still driven when no idle stretch follows
  task automatic send_request(input logic [2:0] op, input logic [7:0] id,
                              input logic [7:0] addr, input logic [7:0] cnt,
                              input logic [7:0] lo, input logic [7:0] hi);
    int gap;
    req_bus.valid       = 1'b1;
    req_bus.opcode      = op;
    req_bus.servo_id    = id;
    req_bus.reg_address = addr;
    req_bus.byte_count  = cnt;
    req_bus.data_lo     = lo;
    req_bus.data_hi     = hi;
    do @(posedge clk_i); while (!req_bus.ready);
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      // junk payload while idle
      req_bus.valid       = 1'b0;
      req_bus.opcode      = 3'($urandom_range(0, 7));
      req_bus.servo_id    = 8'($urandom);
      req_bus.reg_address = 8'($urandom);
      req_bus.byte_count  = 8'($urandom);
      req_bus.data_lo     = 8'($urandom);
      req_bus.data_hi     = 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stop offering and wait until every queued byte has left
  task automatic drain_packets();
    req_bus.valid = 1'b0;
    do @(negedge clk_i); while (pending_bytes != 0);
  endtask

  // Byte sink: random stalls, or one long hold-off on request
  initial begin
    int stall_left;
    stall_left   = 0;
    tx_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        tx_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off     = 1'b0;
        tx_bus.ready = 1'b1;
      end else if (stall_left > 0 && !no_idle) begin
        tx_bus.ready = 1'b0;
        stall_left--;
      end else begin
        tx_bus.ready = 1'b1;
        stall_left   = 0;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Watchdog: too long without any handshake on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (tx_bus.valid && tx_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_servo_bus_instruction_framer: FAIL");
    $finish;
  end

  // Request stimulus and verdict
  initial begin
    int         done;
    logic [2:0] op;
    logic [7:0] id;
    req_bus.valid       = 1'b0;
    req_bus.opcode      = OP_READ;
    req_bus.servo_id    = 8'h00;
    req_bus.reg_address = 8'h00;
    req_bus.byte_count  = 8'h00;
    req_bus.data_lo     = 8'h00;
    req_bus.data_hi     = 8'h00;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, every operation, saturation, ignored fields
    send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(OP_READ, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_READ, 8'h7F, 8'h5A, 8'hA5, 8'h33, 8'hCC);
    send_request(OP_WRITE, 8'h01, 8'h1E, 8'h00, 8'hAA, 8'h55);
    send_request(OP_WRITE, 8'hFE, 8'hFF, 8'h01, 8'hFF, 8'h00);
    send_request(OP_WRITE, 8'h80, 8'h20, 8'h02, 8'h00, 8'hFF);
    send_request(OP_WRITE, 8'h01, 8'h00, 8'h03, 8'h12, 8'h34);
    send_request(OP_WRITE, 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_REG_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(OP_REG_WRITE, 8'hFE, 8'h1E, 8'h01, 8'h3C, 8'hC3);
    send_request(OP_REG_WRITE, 8'h55, 8'hAA, 8'h02, 8'hFF, 8'hFF);
    send_request(OP_REG_WRITE, 8'h2A, 8'h10, 8'hC8, 8'h01, 8'h80);
    send_request(OP_ACTION, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(OP_ACTION, 8'h37, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_RESET, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_RESET, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(OP_RESET, 8'h81, 8'h42, 8'h02, 8'h99, 8'h66);
    send_request(OP_UNDEF_A, 8'h10, 8'h20, 8'h02, 8'h30, 8'h40);
    send_request(OP_UNDEF_B, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_UNDEF_C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(OP_READ, 8'h05, 8'h24, 8'h02, 8'h00, 8'h00);

    // Long sink hold-off while requests keep coming back to back
    drain_packets();
    hold_off = 1'b1;
    no_idle  = 1'b1;
    repeat (10)
      send_request(OP_WRITE, 8'($urandom_range(0, 254)), 8'($urandom), pick_count(),
                   8'($urandom), 8'($urandom));
    no_idle = 1'b0;
    drain_packets();

    // Random requests, a stretch in the middle without idling
    done = 0;
    while (done < RANDOM_ITEMS) begin
      no_idle = (done >= 40 && done < 60);
      if ($urandom_range(0, 9) == 0) begin
        op = 3'($urandom_range(OP_UNDEF_A, OP_UNDEF_C));
      end else begin
        op = 3'($urandom_range(OP_READ, OP_RESET));
        done++;
      end
      id = ($urandom_range(0, 9) == 0) ? BCAST_ID : 8'($urandom_range(0, 254));
      send_request(op, id, 8'($urandom), pick_count(), 8'($urandom), 8'($urandom));
    end
    no_idle = 1'b0;

    drain_packets();
    repeat (SETTLE) @(negedge clk_i);
    if (fail_count == 0 && pending_bytes == 0)
      $display("tb_servo_bus_instruction_framer: PASS");
    else
      $display("tb_servo_bus_instruction_framer: FAIL");
    $finish;
  end

endmodule
